FILE: hdl/vertex_affine_transform_defines.svh
// Assertion macros shared by the vertex transform RTL.
// Included by modules that check their own pipeline behavior.
`ifndef VERTEX_AFFINE_TRANSFORM_DEFINES_SVH
`define VERTEX_AFFINE_TRANSFORM_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define VAT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define VAT_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/vat_pkg.sv
// Package for the vertex transform: payload structs, register and mode codes,
// and the rounding and saturation helpers. No dependencies.
`timescale 1ns / 1ps

package vat_pkg;

  localparam int COORD_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CENTER_W = 10;
  localparam int SCALE_FRAC_BITS = 8;
  localparam int CALC_W = 36;

  localparam logic [CFG_INDEX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FACTOR_X = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_FACTOR_Y = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COS      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SIN      = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 3'd6;

  localparam logic [2:0] MODE_TRANSLATE   = 3'd0;
  localparam logic [2:0] MODE_SCALE       = 3'd1;
  localparam logic [2:0] MODE_ROTATE      = 3'd2;
  localparam logic [2:0] MODE_MIRROR_Y    = 3'd3;
  localparam logic [2:0] MODE_MIRROR_X    = 3'd4;
  localparam logic [2:0] MODE_MIRROR_BOTH = 3'd5;

  localparam logic signed [CFG_W-1:0] COS_RESET = 16'sd16384;
  localparam logic [CENTER_W-1:0] CENTER_X_RESET = 10'd320;
  localparam logic [CENTER_W-1:0] CENTER_Y_RESET = 10'd240;

  localparam logic signed [CALC_W-1:0] SAT_HI = CALC_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [CALC_W-1:0] SAT_LO = -SAT_HI - CALC_W'(1);

  typedef struct packed {
    logic signed [COORD_W-1:0] x_in;
    logic signed [COORD_W-1:0] y_in;
    logic                      first;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_out;
    logic signed [COORD_W-1:0] y_out;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] value;
    logic                      hit;
  } sat_t;

  function automatic logic signed [CALC_W-1:0] trunc_shift(
    input logic signed [CALC_W-1:0] v,
    input int                       s
  );
    logic signed [CALC_W-1:0] bias;
    bias = (CALC_W'(1) <<< s) - CALC_W'(1);
    return v[CALC_W-1] ? ((v + bias) >>> s) : (v >>> s);
  endfunction

  function automatic sat_t saturate(input logic signed [CALC_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.value = SAT_HI[COORD_W-1:0];
      r.hit = 1'b1;
    end else if (v < SAT_LO) begin
      r.value = SAT_LO[COORD_W-1:0];
      r.hit = 1'b1;
    end else begin
      r.value = v[COORD_W-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: hdl/vertex_affine_transform.sv
// vertex_affine_transform: 2D translate, scale, rotate and mirror of polygon
// vertices in signed 16-bit screen coordinates. Depends on vat_pkg and
// vertex_affine_transform_defines.svh.
//
// Vertices enter on in_data with in_valid/in_stall and results leave on
// out_data with out_valid/out_stall; a transfer happens when valid is high
// and stall is low. Registers are written through cfg_we, cfg_index and
// cfg_data. Write them only while no vertex is in flight; the block itself
// does not enforce this. A vertex passes through an input register, then
// the arithmetic (up to four parallel 17x16 multiplies, a rounding add and a
// clamp) into the output register. One vertex per cycle is sustained while
// out_stall is low.
// A vertex marked first loads the scaling pivot when it leaves the input
// register. When the receiver stalls, the output holds and the input register
// keeps one more vertex before in_stall rises.
// Synchronous reset empties both stages, clears the pivot and restores the
// register reset values.
`timescale 1ns / 1ps

module vertex_affine_transform
  import vat_pkg::*;
#(
  parameter int TRIG_FRAC_BITS = 14
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]       cfg_data
);

  logic [2:0]                mode;
  logic signed [CFG_W-1:0]   factor_x;
  logic signed [CFG_W-1:0]   factor_y;
  logic signed [CFG_W-1:0]   cos_value;
  logic signed [CFG_W-1:0]   sin_value;
  logic [CENTER_W-1:0]       center_x;
  logic [CENTER_W-1:0]       center_y;
  logic signed [COORD_W-1:0] pivot_x;
  logic signed [COORD_W-1:0] pivot_y;

  logic      s1_valid;
  in_item_t  s1;
  logic      advance;
  logic      in_fire;
  out_item_t result;

  logic signed [COORD_W:0]          cx;
  logic signed [COORD_W:0]          cy;
  logic signed [COORD_W:0]          xe;
  logic signed [COORD_W:0]          ye;
  logic signed [COORD_W:0]          sdx;
  logic signed [COORD_W:0]          sdy;
  logic signed [COORD_W:0]          rdx;
  logic signed [COORD_W:0]          rdy;
  logic signed [COORD_W+CFG_W:0]    sprod_x;
  logic signed [COORD_W+CFG_W:0]    sprod_y;
  logic signed [COORD_W+CFG_W:0]    p_xc;
  logic signed [COORD_W+CFG_W:0]    p_ys;
  logic signed [COORD_W+CFG_W:0]    p_xs;
  logic signed [COORD_W+CFG_W:0]    p_yc;
  logic signed [CALC_W-1:0]         rx;
  logic signed [CALC_W-1:0]         ry;
  sat_t                             sat_x;
  sat_t                             sat_y;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign in_fire  = in_valid && !in_stall;

  assign cx  = (COORD_W+1)'($signed({1'b0, center_x}));
  assign cy  = (COORD_W+1)'($signed({1'b0, center_y}));
  assign xe  = (COORD_W+1)'(s1.x_in);
  assign ye  = (COORD_W+1)'(s1.y_in);
  assign sdx = xe - (COORD_W+1)'(pivot_x);
  assign sdy = ye - (COORD_W+1)'(pivot_y);
  assign rdx = xe - cx;
  assign rdy = ye - cy;

  assign sprod_x = sdx * factor_x;
  assign sprod_y = sdy * factor_y;
  assign p_xc    = rdx * cos_value;
  assign p_ys    = rdy * sin_value;
  assign p_xs    = rdx * sin_value;
  assign p_yc    = rdy * cos_value;

  always_comb begin
    rx = CALC_W'(s1.x_in);
    ry = CALC_W'(s1.y_in);
    case (mode)
      MODE_TRANSLATE: begin
        rx = CALC_W'(s1.x_in) + CALC_W'(factor_x);
        ry = CALC_W'(s1.y_in) - CALC_W'(factor_y);
      end
      MODE_SCALE: begin
        if (!s1.first) begin
          rx = CALC_W'(pivot_x) + trunc_shift(CALC_W'(sprod_x), SCALE_FRAC_BITS);
          ry = CALC_W'(pivot_y) + trunc_shift(CALC_W'(sprod_y), SCALE_FRAC_BITS);
        end
      end
      MODE_ROTATE: begin
        rx = CALC_W'(cx) + trunc_shift(CALC_W'(p_xc) - CALC_W'(p_ys), TRIG_FRAC_BITS);
        ry = CALC_W'(cy) + trunc_shift(CALC_W'(p_xs) + CALC_W'(p_yc), TRIG_FRAC_BITS);
      end
      MODE_MIRROR_Y: begin
        ry = (CALC_W'(cy) <<< 1) - CALC_W'(s1.y_in);
      end
      MODE_MIRROR_X: begin
        rx = (CALC_W'(cx) <<< 1) - CALC_W'(s1.x_in);
      end
      MODE_MIRROR_BOTH: begin
        rx = (CALC_W'(cx) <<< 1) - CALC_W'(s1.x_in);
        ry = (CALC_W'(cy) <<< 1) - CALC_W'(s1.y_in);
      end
      default: begin
      end
    endcase
    sat_x = saturate(rx);
    sat_y = saturate(ry);
    result.x_out = sat_x.value;
    result.y_out = sat_y.value;
    result.saturated = sat_x.hit || sat_y.hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pivot_x   <= '0;
      pivot_y   <= '0;
      mode      <= MODE_TRANSLATE;
      factor_x  <= '0;
      factor_y  <= '0;
      cos_value <= COS_RESET;
      sin_value <= '0;
      center_x  <= CENTER_X_RESET;
      center_y  <= CENTER_Y_RESET;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid && s1.first) begin
          pivot_x <= s1.x_in;
          pivot_y <= s1.y_in;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MODE:     mode      <= cfg_data[2:0];
          REG_FACTOR_X: factor_x  <= cfg_data;
          REG_FACTOR_Y: factor_y  <= cfg_data;
          REG_COS:      cos_value <= cfg_data;
          REG_SIN:      sin_value <= cfg_data;
          REG_CENTER_X: center_x  <= cfg_data[CENTER_W-1:0];
          REG_CENTER_Y: center_y  <= cfg_data[CENTER_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1 <= in_data;
    end
    if (advance && s1_valid) begin
      out_data <= result;
    end
  end

`include "vertex_affine_transform_defines.svh"

  `VAT_ASSERT_NEXT(a_hold_input, clk, rst, s1_valid && !advance, s1_valid && $stable(s1), "input register lost a stalled vertex")
  `VAT_ASSERT_NEXT(a_move_out, clk, rst, s1_valid && advance, out_valid, "vertex did not reach the output register")
  `VAT_ASSERT_NEXT(a_pivot_load, clk, rst, s1_valid && advance && s1.first, pivot_x == $past(s1.x_in) && pivot_y == $past(s1.y_in), "pivot not loaded from first vertex")

endmodule
